// ----- rtl/core/srps_pkg.sv -----
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types, constants and helpers of the servo ramp profile sequencer.
// ----------------------------------------------------------------------------
package srps_pkg;

  // field widths
  localparam int ANGLE_W    = 8;
  localparam int TIME_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // interpolation arithmetic: step * elapsed, 8 quotient bits
  localparam int PROD_W = ANGLE_W + TIME_W;
  localparam int QUO_W  = ANGLE_W;
  localparam int DVS_W  = TIME_W + QUO_W - 1;

  localparam int SEGMENTS_DEF = 16;

  // reset values of the limit registers
  localparam logic [ANGLE_W-1:0] OPEN_LIMIT_RST   = 8'd180;
  localparam logic [ANGLE_W-1:0] CLOSED_LIMIT_RST = 8'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LIMIT = 1'b1;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIRECT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NORMAL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REWIND = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic tick_end;
    logic ram_rd;
    logic seg_done;
    logic mul_load;
    logic div_step;
    logic ramp_write;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              tick_live;
    logic              past_end;
    logic              elapsed_ge;
    logic              div_last;
  } dp_sts_t;

  function automatic logic [ANGLE_W-1:0] sat8(input logic [ANGLE_W:0] v);
    return v[ANGLE_W] ? {ANGLE_W{1'b1}} : v[ANGLE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/srps_ram.sv -----
// ----------------------------------------------------------------------------
// srps_ram
// Generic single port RAM with registered read data.
// ----------------------------------------------------------------------------
module srps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/srps_dp.sv -----
// ----------------------------------------------------------------------------
// srps_dp
// Datapath: segment table, profile state, interpolation divider, result regs.
// ----------------------------------------------------------------------------
module srps_dp #(
  parameter int SEGMENTS = srps_pkg::SEGMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [srps_pkg::FUNC_W-1:0]      in_func,
  input  logic [srps_pkg::ANGLE_W-1:0]     in_angle_value,
  input  logic [srps_pkg::TIME_W-1:0]      in_time_value,
  input  srps_pkg::dp_cmd_t                cmd,
  output srps_pkg::dp_sts_t                sts,
  output logic [srps_pkg::ANGLE_W-1:0]     out_servo_angle,
  output logic [srps_pkg::ANGLE_W-1:0]     out_position,
  output logic                             out_accepted,
  output logic                             out_profile_done,
  output logic                             out_command_mode
);

  import srps_pkg::*;

  localparam int IDX_W  = $clog2(SEGMENTS);
  localparam int CNT_W  = $clog2(QUO_W);
  localparam int ROW_W  = 2 * ANGLE_W + TIME_W;

  // item registers
  logic [FUNC_W-1:0]  func_r;
  logic [ANGLE_W-1:0] ang_r;
  logic [TIME_W-1:0]  tv_r;
  logic [TIME_W-1:0]  elapsed_r;

  // profile state
  logic [IDX_W-1:0]   seg_count_r;
  logic [IDX_W-1:0]   seg_index_r;
  logic [TIME_W-1:0]  start_time_r;
  logic [ANGLE_W-1:0] held_r;
  logic               mode_r;
  logic               running_r;
  logic               finished_r;
  logic               acc_r;
  logic [ANGLE_W-1:0] last_total_r;
  logic [ANGLE_W-1:0] prev_total_r;
  logic [ANGLE_W-1:0] open_r;
  logic [ANGLE_W-1:0] closed_r;

  // divider
  logic [PROD_W-1:0]  rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [QUO_W-1:0]   quo_r;
  logic [CNT_W-1:0]   div_cnt_r;

  // result payload
  logic [ANGLE_W-1:0] o_angle_r;
  logic [ANGLE_W-1:0] o_pos_r;
  logic               o_acc_r;
  logic               o_done_r;
  logic               o_mode_r;

  logic               table_full;
  logic [ANGLE_W-1:0] add_total;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]   ram_rdata;
  logic [ANGLE_W-1:0] rd_step;
  logic [ANGLE_W-1:0] rd_total;
  logic [TIME_W-1:0]  rd_dur;
  logic [IDX_W-1:0]   idx_inc;
  logic               rem_ge;
  logic [ANGLE_W-1:0] drive;

  assign table_full = (seg_count_r == IDX_W'(SEGMENTS - 1));
  assign add_total  = sat8({1'b0, last_total_r} + {1'b0, ang_r});
  assign ram_we     = cmd.exec && (func_r == FUNC_ADD) && !table_full;
  // adds write at the fill count, ticks read the current segment
  assign ram_addr   = ram_we ? seg_count_r : seg_index_r;
  assign ram_wdata  = {ang_r, add_total, tv_r};
  assign {rd_step, rd_total, rd_dur} = ram_rdata;
  assign idx_inc    = seg_index_r + IDX_W'(1);
  assign rem_ge     = (rem_r >= {1'b0, dvs_r});

  always_comb begin
    if (held_r > open_r) begin
      drive = open_r;
    end else if (held_r < closed_r) begin
      drive = closed_r;
    end else begin
      drive = held_r;
    end
  end

  srps_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .rd_en (cmd.ram_rd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r  <= '0;
      seg_index_r  <= '0;
      start_time_r <= '0;
      held_r       <= CLOSED_LIMIT_RST;
      mode_r       <= 1'b0;
      running_r    <= 1'b0;
      finished_r   <= 1'b0;
      acc_r        <= 1'b0;
      last_total_r <= '0;
      prev_total_r <= '0;
      open_r       <= OPEN_LIMIT_RST;
      closed_r     <= CLOSED_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OPEN_LIMIT:   open_r   <= cfg_wdata;
          CFG_CLOSED_LIMIT: closed_r <= cfg_wdata;
          default:          ;
        endcase
      end
      if (cmd.exec) begin
        unique case (func_r)
          FUNC_ADD: begin
            acc_r <= !table_full;
            if (!table_full) begin
              last_total_r <= add_total;
              seg_count_r  <= seg_count_r + IDX_W'(1);
            end
          end
          FUNC_START: begin
            acc_r     <= 1'b1;
            running_r <= 1'b1;
            mode_r    <= 1'b1;
            if (start_time_r == '0) begin
              start_time_r <= tv_r;
            end
          end
          FUNC_TICK: acc_r <= 1'b1;
          FUNC_DIRECT: begin
            acc_r <= 1'b1;
            if (!mode_r) begin
              held_r <= ang_r;
            end
          end
          FUNC_NORMAL: begin
            acc_r  <= 1'b1;
            mode_r <= 1'b0;
          end
          FUNC_REWIND: begin
            acc_r        <= 1'b1;
            seg_index_r  <= '0;
            prev_total_r <= '0;
            finished_r   <= 1'b0;
          end
          default: acc_r <= 1'b0;
        endcase
      end
      if (cmd.tick_end) begin
        finished_r <= 1'b1;
      end
      if (cmd.seg_done) begin
        held_r       <= rd_total;
        prev_total_r <= rd_total;
        start_time_r <= start_time_r + rd_dur;
        seg_index_r  <= idx_inc;
        if (idx_inc >= seg_count_r) begin
          finished_r <= 1'b1;
        end
      end
      if (cmd.ramp_write) begin
        held_r <= sat8({1'b0, prev_total_r} + {1'b0, quo_r});
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r    <= in_func;
      ang_r     <= in_angle_value;
      tv_r      <= in_time_value;
      elapsed_r <= in_time_value - start_time_r;
    end
    if (cmd.mul_load) begin
      rem_r     <= {{TIME_W{1'b0}}, rd_step} * {{ANGLE_W{1'b0}}, elapsed_r};
      dvs_r     <= {rd_dur, {(QUO_W-1){1'b0}}};
      quo_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - {1'b0, dvs_r};
      end
      quo_r     <= {quo_r[QUO_W-2:0], rem_ge};
      dvs_r     <= dvs_r >> 1;
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      o_angle_r <= drive;
      o_pos_r   <= held_r;
      o_acc_r   <= acc_r;
      o_done_r  <= finished_r;
      o_mode_r  <= mode_r;
    end
  end

  assign sts.func       = func_r;
  assign sts.tick_live  = mode_r && running_r && !finished_r;
  assign sts.past_end   = (seg_index_r >= seg_count_r);
  assign sts.elapsed_ge = (elapsed_r >= rd_dur);
  assign sts.div_last   = (div_cnt_r == CNT_W'(QUO_W - 1));

  assign out_servo_angle  = o_angle_r;
  assign out_position     = o_pos_r;
  assign out_accepted     = o_acc_r;
  assign out_profile_done = o_done_r;
  assign out_command_mode = o_mode_r;

`ifndef SYNTHESIS
  a_idx_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    seg_index_r <= seg_count_r)
    else $error("segment index beyond loaded count");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    seg_count_r <= IDX_W'(SEGMENTS - 1))
    else $error("segment count beyond table size");

  a_last_seg_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seg_done && (idx_inc >= seg_count_r) |=> finished_r)
    else $error("last segment completed without finishing");
`endif

endmodule

// ----- rtl/core/srps_ctrl.sv -----
// ----------------------------------------------------------------------------
// srps_ctrl
// Controller: sequences one item through decode, table read, divide, result.
// ----------------------------------------------------------------------------
module srps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  srps_pkg::dp_sts_t sts,
  output srps_pkg::dp_cmd_t cmd
);

  import srps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
        if ((sts.func == FUNC_TICK) && sts.tick_live) begin
          if (sts.past_end) begin
            cmd.tick_end = 1'b1;
          end else begin
            cmd.ram_rd = 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      S_RD: begin
        if (sts.elapsed_ge) begin
          cmd.seg_done = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.ramp_write = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while still pending");

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && sts.div_last |=> (state_r == S_FIN))
    else $error("divider did not hand over to ramp write");

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> (state_r == S_EXEC) && in_stall)
    else $error("accepted item not decoded");
`endif

endmodule

// ----- rtl/core/servo_ramp_profile_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// servo_ramp_profile_sequencer_core
// Piecewise linear servo position profiler with a segment table, a serial
// interpolation divider and clamped drive output.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  func, angle_value, time_value
// out_      output     out_valid / out_stall servo_angle, position, accepted,
//                                           profile_done, command_mode
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// an item that needs no table read goes from decode straight to the result;
// a live tick reads its segment from the table and, unless the segment completes,
// runs the 8-step restoring divider (one quotient bit a cycle)
// one item is in flight; the next is taken while a result waits in the output
// register, and out_stall holds that register
// rst_n is synchronous; the segment table needs no clearing pass, entries are
// only read below the fill count
//
module servo_ramp_profile_sequencer_core #(
  parameter int SEGMENTS = srps_pkg::SEGMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [srps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // item input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srps_pkg::FUNC_W-1:0]      in_func,
  input  logic [srps_pkg::ANGLE_W-1:0]     in_angle_value,
  input  logic [srps_pkg::TIME_W-1:0]      in_time_value,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srps_pkg::ANGLE_W-1:0]     out_servo_angle,
  output logic [srps_pkg::ANGLE_W-1:0]     out_position,
  output logic                             out_accepted,
  output logic                             out_profile_done,
  output logic                             out_command_mode
);

  import srps_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one state per phase of an item, owns both handshakes
  srps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: segment table ram, profile registers, multiplier and divider,
  // limit registers and the result register
  srps_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_func),
    .in_angle_value   (in_angle_value),
    .in_time_value    (in_time_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_servo_angle  (out_servo_angle),
    .out_position     (out_position),
    .out_accepted     (out_accepted),
    .out_profile_done (out_profile_done),
    .out_command_mode (out_command_mode)
  );

endmodule
